### rtl/bc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bc_pkg;

  // Default width of the n and r operands used inside the block.
  localparam int unsigned N_WIDTH_DEF = 8;

  // Width of the input ports, fixed by the interface.
  localparam int unsigned FIELD_W = 8;

  // Width of the result value.
  localparam int unsigned COEF_W = 64;

  // Quotient bits retired per division cycle.
  localparam int unsigned DIV_STEP = 8;

  // Microprogram counter.
  localparam int unsigned PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_SETUP  = 3'd1;
  localparam pc_t PC_LOOP   = 3'd2;
  localparam pc_t PC_MUL    = 3'd3;
  localparam pc_t PC_DIV    = 3'd4;
  localparam pc_t PC_UPDATE = 3'd5;
  localparam pc_t PC_FINISH = 3'd6;
  localparam pc_t PC_RETURN = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_MUL,
    OP_DIV,
    OP_UPDATE,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_INVALID,
    COND_LOOP_DONE,
    COND_DIV_MORE,
    COND_NO_OVF,
    COND_OUT_BUSY
  } cond_e;

  // One microinstruction: datapath operation, jump condition, jump target.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_word_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_e  op;
    logic in_ready;
  } seq_ctrl_t;

  // Datapath to sequencer: jump conditions.
  typedef struct packed {
    logic in_valid;
    logic invalid;
    logic loop_done;
    logic div_more;
    logic no_ovf;
    logic out_busy;
  } dp_status_t;

  // Microprogram. A taken jump goes to target, otherwise to the next step.
  function automatic ctrl_word_t rom_word(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_LOAD,   cond: COND_NO_INPUT,  target: PC_IDLE};
      PC_SETUP:  w = '{op: OP_SETUP,  cond: COND_INVALID,   target: PC_FINISH};
      PC_LOOP:   w = '{op: OP_NONE,   cond: COND_LOOP_DONE, target: PC_FINISH};
      PC_MUL:    w = '{op: OP_MUL,    cond: COND_NEVER,     target: PC_IDLE};
      PC_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE,  target: PC_DIV};
      PC_UPDATE: w = '{op: OP_UPDATE, cond: COND_NO_OVF,    target: PC_LOOP};
      PC_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_BUSY,  target: PC_FINISH};
      PC_RETURN: w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: PC_IDLE};
      default:   w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: returns C(n, r) for one (n, r) pair.
// Input channel: in_valid_i / in_ready_o with n_i, r_i. One transfer per pair;
//   in_ready_o is high only while the sequencer sits at its idle step.
// Output channel: out_valid_o / out_ready_i with coefficient_o, overflow_o,
//   invalid_o. One result transfer per input transfer, in order.
// Invalid pairs (n < r, n == 0 or r == 0) give zero with invalid_o set; a
//   result above 64 bits gives all ones with overflow_o set.
// Each pair is worked by setup and then, with k = min(r, n - r), a loop of
//   k passes of a loop-control step, a multiply step, a repeated divide step
//   and an update step, then a finish step. An invalid pair goes from setup
//   straight to finish; an overflow ends the loop early. One pair is worked
//   at a time, so the next input transfer is taken only after the last pair
//   has passed its finish step.
// A finished result sits in the output register; if the receiver stalls, the
//   next pair is still taken and worked, and its finish step waits there
//   until the output register frees up.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   out_valid_o; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_unit #(
  parameter int unsigned N_WIDTH = bc_pkg::N_WIDTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [bc_pkg::FIELD_W-1:0] n_i,
  input  wire  [bc_pkg::FIELD_W-1:0] r_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [bc_pkg::COEF_W-1:0]  coefficient_o,
  output logic                       overflow_o,
  output logic                       invalid_o
);

  bc_pkg::seq_ctrl_t  ctrl;
  bc_pkg::dp_status_t status;

  // Microcode ROM, step counter and jump logic.
  bc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Accumulator, multiplier, radix-256 divider and output register.
  bc_datapath #(
    .N_WIDTH (N_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_valid_i    (in_valid_i),
    .n_i           (n_i),
    .r_i           (r_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .overflow_o    (overflow_o),
    .invalid_o     (invalid_o)
  );

  assign in_ready_o = ctrl.in_ready;

endmodule

`default_nettype wire

### rtl/bc_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module bc_sequencer (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bc_pkg::dp_status_t status_i,
  output bc_pkg::seq_ctrl_t  ctrl_o
);

  bc_pkg::pc_t        pc_q, pc_d;
  bc_pkg::ctrl_word_t word;
  logic               take;

  assign word = bc_pkg::rom_word(pc_q);

  always_comb begin
    unique case (word.cond)
      bc_pkg::COND_NEVER:     take = 1'b0;
      bc_pkg::COND_ALWAYS:    take = 1'b1;
      bc_pkg::COND_NO_INPUT:  take = ~status_i.in_valid;
      bc_pkg::COND_INVALID:   take = status_i.invalid;
      bc_pkg::COND_LOOP_DONE: take = status_i.loop_done;
      bc_pkg::COND_DIV_MORE:  take = status_i.div_more;
      bc_pkg::COND_NO_OVF:    take = status_i.no_ovf;
      bc_pkg::COND_OUT_BUSY:  take = status_i.out_busy;
      default:                take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = take ? word.target : pc_q + bc_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bc_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op       = word.op;
  assign ctrl_o.in_ready = (pc_q == bc_pkg::PC_IDLE);

endmodule

`default_nettype wire

### rtl/bc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bc_datapath #(
  parameter int unsigned N_WIDTH = bc_pkg::N_WIDTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  bc_pkg::seq_ctrl_t                ctrl_i,
  output bc_pkg::dp_status_t               status_o,
  input  wire                              in_valid_i,
  input  wire  [bc_pkg::FIELD_W-1:0]       n_i,
  input  wire  [bc_pkg::FIELD_W-1:0]       r_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [bc_pkg::COEF_W-1:0]        coefficient_o,
  output logic                             overflow_o,
  output logic                             invalid_o
);

  localparam int unsigned IW      = N_WIDTH;
  localparam int unsigned CW      = bc_pkg::COEF_W;
  localparam int unsigned STEP    = bc_pkg::DIV_STEP;
  // Product / quotient register, padded to whole division cycles.
  localparam int unsigned DW      = ((CW + IW + STEP - 1) / STEP) * STEP;
  localparam int unsigned DIV_CYC = DW / STEP;
  localparam int unsigned CNT_W   = $clog2(DIV_CYC);

  logic [15:0]       n_ext, r_ext;
  logic [IW-1:0]     n_m, r_m;

  logic [IW-1:0]     n_q, r_q, k_q, base_q, i_q;
  logic [IW-1:0]     rem_q;
  logic [CW-1:0]     acc_q;
  logic [DW-1:0]     quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ovf_q, inv_q;

  logic              out_valid_q;
  logic [CW-1:0]     coef_q;
  logic              out_ovf_q, out_inv_q;

  logic              invalid_c;
  logic [IW-1:0]     nmr_c, k_c, num_c;
  logic [DW-1:0]     prod_c;
  logic [DW-1:0]     dq_c;
  logic [IW:0]       dr_c;
  logic              hi_nz_c;
  logic              out_busy_c;
  logic              finish_c;

  // Operands keep only their low N_WIDTH bits.
  assign n_ext = 16'(n_i);
  assign r_ext = 16'(r_i);
  assign n_m   = n_ext[IW-1:0];
  assign r_m   = r_ext[IW-1:0];

  assign invalid_c = (n_q == '0) || (r_q == '0) || (n_q < r_q);
  assign nmr_c     = n_q - r_q;
  assign k_c       = (r_q < nmr_c) ? r_q : nmr_c;
  assign num_c     = base_q + i_q;
  assign prod_c    = DW'(acc_q) * DW'(num_c);
  assign hi_nz_c   = (quo_q[DW-1:CW] != '0);

  // Restoring division, several quotient bits per cycle; remainder stays narrow.
  always_comb begin
    dq_c = quo_q;
    dr_c = {1'b0, rem_q};
    for (int s = 0; s < STEP; s++) begin
      dr_c = {dr_c[IW-1:0], dq_c[DW-1]};
      dq_c = {dq_c[DW-2:0], 1'b0};
      if (dr_c >= {1'b0, i_q}) begin
        dr_c    = dr_c - {1'b0, i_q};
        dq_c[0] = 1'b1;
      end
    end
  end

  assign out_busy_c = out_valid_q & ~out_ready_i;
  assign finish_c   = (ctrl_i.op == bc_pkg::OP_FINISH) && !out_busy_c;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      bc_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          n_q <= n_m;
          r_q <= r_m;
        end
      end
      bc_pkg::OP_SETUP: begin
        k_q    <= k_c;
        base_q <= n_q - k_c;
        acc_q  <= CW'(1);
        i_q    <= IW'(1);
        ovf_q  <= 1'b0;
        inv_q  <= invalid_c;
      end
      bc_pkg::OP_MUL: begin
        quo_q <= prod_c;
        rem_q <= '0;
        cnt_q <= '0;
      end
      bc_pkg::OP_DIV: begin
        quo_q <= dq_c;
        rem_q <= dr_c[IW-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      bc_pkg::OP_UPDATE: begin
        acc_q <= quo_q[CW-1:0];
        i_q   <= i_q + IW'(1);
        if (hi_nz_c) begin
          ovf_q <= 1'b1;
        end
      end
      bc_pkg::OP_FINISH: begin
        if (finish_c) begin
          coef_q    <= inv_q ? '0 : (ovf_q ? '1 : acc_q);
          out_ovf_q <= ~inv_q & ovf_q;
          out_inv_q <= inv_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_c) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.in_valid  = in_valid_i;
  assign status_o.invalid   = invalid_c;
  assign status_o.loop_done = (i_q > k_q);
  assign status_o.div_more  = (cnt_q != CNT_W'(DIV_CYC - 1));
  assign status_o.no_ovf    = ~hi_nz_c;
  assign status_o.out_busy  = out_busy_c;

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign overflow_o    = out_ovf_q;
  assign invalid_o     = out_inv_q;

endmodule

`default_nettype wire

### tb/sv/binomial_coefficient_unit_test.sv
`timescale 1ns / 1ps

module binomial_coefficient_unit_test;

  import bc_pkg::*;

  localparam int unsigned OPERAND_W  = N_WIDTH_DEF;
  // The drain window and the watchdog are both taken well above the time
  // that the slowest pair needs.
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_PAIRS = 270;
  localparam logic [COEF_W-1:0] ALL_ONES = '1;

  // One expected result, field for field as the output ports carry it.
  typedef struct {
    logic [COEF_W-1:0] coefficient;
    logic              overflow;
    logic              invalid;
  } binom_result_t;

  // Keeps the results still owed by the block, in transfer order.
  class binomial_ledger;
    binom_result_t owed_results[$];
    int unsigned   failures;

    function new();
      failures = 0;
    endfunction

    // C(n, r) by the multiplicative form; each step is made exact by first
    // reducing the running value and the step index by their gcd.
    function binom_result_t choose(input logic [FIELD_W-1:0] n_raw,
                                   input logic [FIELD_W-1:0] r_raw);
      binom_result_t    res;
      longint unsigned  n, r, k, i, acc, num, g, a, den, b, x, y, t;
      n = n_raw & ((64'd1 << OPERAND_W) - 1);
      r = r_raw & ((64'd1 << OPERAND_W) - 1);
      res = '{coefficient: '0, overflow: 1'b0, invalid: 1'b1};
      if (n == 0 || r == 0 || n < r) return res;
      k = n - r;
      if (r < k) k = r;
      acc = 1;
      for (i = 1; i <= k; i++) begin
        num = n - k + i;
        x = acc;
        y = i;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        g   = x;
        a   = acc / g;
        den = i / g;
        b   = num / den;
        // Any step overflowing means the final value overflows too.
        if (a > ALL_ONES / b) begin
          res = '{coefficient: ALL_ONES, overflow: 1'b1, invalid: 1'b0};
          return res;
        end
        acc = a * b;
      end
      res = '{coefficient: acc, overflow: 1'b0, invalid: 1'b0};
      return res;
    endfunction

    function void note_pair(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] r);
      owed_results.push_back(choose(n, r));
    endfunction

    function void check_result(input logic [COEF_W-1:0] coefficient,
                               input logic overflow, input logic invalid);
      binom_result_t exp_res;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: coefficient %h overflow %b invalid %b",
                 $time, coefficient, overflow, invalid);
        failures++;
        return;
      end
      exp_res = owed_results.pop_front();
      if (coefficient !== exp_res.coefficient) begin
        $display("%0t: coefficient mismatch: expected %h, actual %h",
                 $time, exp_res.coefficient, coefficient);
        failures++;
      end
      if (overflow !== exp_res.overflow) begin
        $display("%0t: overflow mismatch: expected %b, actual %b",
                 $time, exp_res.overflow, overflow);
        failures++;
      end
      if (invalid !== exp_res.invalid) begin
        $display("%0t: invalid mismatch: expected %b, actual %b",
                 $time, exp_res.invalid, invalid);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FIELD_W-1:0] n_i;
  logic [FIELD_W-1:0] r_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [COEF_W-1:0]  coefficient_o;
  logic               overflow_o;
  logic               invalid_o;

  binomial_ledger  ledger;
  // While set, neither side inserts idle cycles.
  bit              calm;
  longint unsigned cycle_count;

  binomial_coefficient_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .n_i           (n_i),
    .r_i           (r_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .overflow_o    (overflow_o),
    .invalid_o     (invalid_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready drops in roughly one cycle in ten, except while calm.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= calm || ($urandom_range(99) >= 10);
  end

  // Output transfers are taken at the rising edge, pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.check_result(coefficient_o, overflow_o, invalid_o);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid is lowered only inside an idle gap, so it is never written twice
  // in one time step.
  task automatic send_pair(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] r);
    if (!calm) begin
      while ($urandom_range(99) < 10) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    n_i        <= n;
    r_i        <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_pair(n, r);
    @(negedge clk_i);
  endtask

  // Hold the sender off until the block has returned everything it owes.
  task automatic wait_for_empty();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [FIELD_W-1:0] n, r;
    int unsigned        pick;
    ledger      = new();
    calm        = 1'b0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    n_i         = '0;
    r_i         = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: invalid pairs (zeros, n below r), equal elements, field
    // extremes, the largest values that still fit and the first that overflow.
    send_pair(8'd0,   8'd0);
    send_pair(8'd0,   8'd5);
    send_pair(8'd5,   8'd0);
    send_pair(8'd0,   8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd3,   8'd5);
    send_pair(8'd254, 8'd255);
    send_pair(8'd1,   8'd1);
    send_pair(8'd255, 8'd255);
    send_pair(8'd2,   8'd1);
    send_pair(8'd255, 8'd1);
    send_pair(8'd255, 8'd254);
    send_pair(8'd10,  8'd5);
    send_pair(8'd62,  8'd31);
    send_pair(8'd66,  8'd33);
    send_pair(8'd67,  8'd33);
    send_pair(8'd67,  8'd34);
    send_pair(8'd68,  8'd34);
    send_pair(8'd64,  8'd32);
    send_pair(8'd100, 8'd50);
    send_pair(8'd128, 8'd64);
    send_pair(8'd255, 8'd127);
    send_pair(8'd255, 8'd128);
    send_pair(8'd170, 8'd85);

    // Random: mostly well-formed pairs, weighted toward the range where the
    // result still fits, plus fully random noise.
    for (int unsigned idx = 0; idx < RANDOM_PAIRS; idx++) begin
      if (idx == 60) wait_for_empty();
      calm = (idx >= 120 && idx < 190);
      pick = $urandom_range(99);
      if (pick < 40) begin
        n = FIELD_W'($urandom_range(70, 1));
        r = FIELD_W'($urandom_range(n, 1));
      end else if (pick < 70) begin
        n = FIELD_W'($urandom_range(255, 1));
        r = FIELD_W'($urandom_range(n, 1));
      end else begin
        n = FIELD_W'($urandom());
        r = FIELD_W'($urandom());
      end
      send_pair(n, r);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
